// ===== rtl/tbc_pkg.sv =====
// Shared types, constants and register codes of the thresholded blob centroid core.
`default_nettype none
package tbc_pkg;

	localparam int PIX_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 28;
	localparam int SIZE_W     = 11;
	localparam int WGT_W      = 28;
	localparam int OFS_W      = 12;
	localparam int CENT_W     = 17;
	localparam int CNT_OUT_W  = 11;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_FRAC_BITS  = 4;

	localparam logic [PIX_W-1:0]  LIT_VALUE  = 8'd255;
	localparam int                LIT_SHIFT  = 8;
	localparam int                MIN_RUN    = 5;
	localparam logic [CENT_W-1:0] CENT_MAX   = {CENT_W{1'b1}};
	localparam logic [WGT_W-1:0]  WEIGHT_MAX = {WGT_W{1'b1}};

	localparam logic [PIX_W-1:0]  RST_THRESHOLD  = 8'd20;
	localparam logic [SIZE_W-1:0] RST_FRAME_SIZE = 11'd1024;
	localparam logic [WGT_W-1:0]  RST_MIN_WEIGHT = 28'd0;
	localparam logic [WGT_W-1:0]  RST_MAX_WEIGHT = 28'd267386880;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD,
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT,
		REG_MIN_WEIGHT,
		REG_MAX_WEIGHT,
		REG_WEIGHT_CHECK_ON,
		REG_OFFSET_X,
		REG_OFFSET_Y
	} reg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0]     pixel_out;
		logic                 frame_done;
		logic                 object_found;
		logic                 object_hold;
		logic [CENT_W-1:0]    centroid_x;
		logic [CENT_W-1:0]    centroid_y;
		logic [CNT_OUT_W-1:0] widest_row;
		logic [CNT_OUT_W-1:0] rows_lit;
		logic [WGT_W-1:0]     blob_weight;
	} res_t;

	typedef struct packed {
		logic step;
		logic div_step;
		logic push_final;
		logic push;
	} dp_cmd_t;

	typedef struct packed {
		logic frame_end;
		logic div_last;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/tbc_ifs.sv =====
// Pixel and result stream interfaces.
`default_nettype none
interface tbc_pix_if;
	import tbc_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_in;
	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

interface tbc_res_if;
	import tbc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [PIX_W-1:0]     pixel_out;
	logic                 frame_done;
	logic                 object_found;
	logic                 object_hold;
	logic [CENT_W-1:0]    centroid_x;
	logic [CENT_W-1:0]    centroid_y;
	logic [CNT_OUT_W-1:0] widest_row;
	logic [CNT_OUT_W-1:0] rows_lit;
	logic [WGT_W-1:0]     blob_weight;
	modport source (output valid, output pixel_out, output frame_done, output object_found,
		output object_hold, output centroid_x, output centroid_y, output widest_row,
		output rows_lit, output blob_weight, input ready);
	modport sink (input valid, input pixel_out, input frame_done, input object_found,
		input object_hold, input centroid_x, input centroid_y, input widest_row,
		input rows_lit, input blob_weight, output ready);
endinterface
`default_nettype wire

// ===== rtl/tbc_ctrl.sv =====
// Controller: pixel acceptance, end-of-frame divide sequencing, result push.
`default_nettype none
module tbc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             q_full,
	input  tbc_pkg::dp_sts_t sts,
	output tbc_pkg::dp_cmd_t cmd
);
	import tbc_pkg::*;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_RUN) && !q_full;

	always_comb begin
		cmd.step       = in_valid && in_ready;
		cmd.div_step   = (state_q == ST_DIV);
		cmd.push_final = (state_q == ST_FIN);
		cmd.push       = (cmd.step && !sts.frame_end) || cmd.push_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (cmd.step && sts.frame_end) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (sts.div_last) state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tbc_dp.sv =====
// Datapath: configuration registers, frame accumulators, restoring dividers, result word.
`default_nettype none
module tbc_dp #(
	parameter int MAX_WIDTH  = tbc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = tbc_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = tbc_pkg::DEF_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [tbc_pkg::PIX_W-1:0]      pixel_in,
	input  tbc_pkg::dp_cmd_t               cmd,
	output tbc_pkg::dp_sts_t               sts,
	output tbc_pkg::res_t                  res
);
	import tbc_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int WD_W   = $clog2(MAX_WIDTH + 1);
	localparam int HT_W   = $clog2(MAX_HEIGHT + 1);
	localparam int CMPW_W = ((WD_W > SIZE_W) ? WD_W : SIZE_W) + 1;
	localparam int CMPH_W = ((HT_W > SIZE_W) ? HT_W : SIZE_W) + 1;
	localparam int RUN_W  = $clog2(MAX_WIDTH + 1);
	localparam int ROWS_W = $clog2(MAX_HEIGHT + 1);
	localparam int LIT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int MAXD   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam longint MOM_MAX = longint'(MAXD - 1) * longint'(MAX_WIDTH)
		* longint'(MAX_HEIGHT);
	localparam int MOM_W  = $clog2(MOM_MAX + 1);
	localparam int QW     = MOM_W + FRAC_BITS;
	localparam int CNT_W  = $clog2(QW);
	localparam int LW_W   = LIT_W + LIT_SHIFT;
	localparam int CW_W   = (LW_W > WGT_W) ? LW_W : WGT_W;
	localparam int SUM_A  = (QW > OFS_W + FRAC_BITS) ? QW : OFS_W + FRAC_BITS;
	localparam int SUM_W  = ((SUM_A > CENT_W) ? SUM_A : CENT_W) + 1;
	localparam int WX_W   = RUN_W + CNT_OUT_W;
	localparam int RX_W   = ROWS_W + CNT_OUT_W;

	logic [PIX_W-1:0]  threshold_q;
	logic [SIZE_W-1:0] frame_width_q;
	logic [SIZE_W-1:0] frame_height_q;
	logic [WGT_W-1:0]  min_weight_q;
	logic [WGT_W-1:0]  max_weight_q;
	logic              weight_check_on_q;
	logic [OFS_W-1:0]  offset_x_q;
	logic [OFS_W-1:0]  offset_y_q;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [LIT_W-1:0]  lit_q;
	logic [MOM_W-1:0]  cm_q;
	logic [MOM_W-1:0]  rm_q;
	logic [RUN_W-1:0]  run_q;
	logic [RUN_W-1:0]  wide_q;
	logic [ROWS_W-1:0] rows_q;
	logic [CENT_W-1:0] last_x_q;
	logic [CENT_W-1:0] last_y_q;

	logic [QW-1:0]     dvx_q;
	logic [QW-1:0]     dvy_q;
	logic [LIT_W-1:0]  remx_q;
	logic [LIT_W-1:0]  remy_q;
	logic [LIT_W-1:0]  dvs_q;
	logic [RUN_W-1:0]  wide_f_q;
	logic [ROWS_W-1:0] rows_f_q;
	logic              pix_f_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [WD_W-1:0]   w_eff;
	logic [HT_W-1:0]   h_eff;
	logic              lit;
	logic              row_end;
	logic              frame_end;
	logic [LIT_W-1:0]  lit_nx;
	logic [MOM_W-1:0]  cm_nx;
	logic [MOM_W-1:0]  rm_nx;
	logic [RUN_W-1:0]  run_nx;
	logic [RUN_W-1:0]  wide_nx;
	logic [ROWS_W-1:0] rows_nx;

	logic [LIT_W:0]    tmp_x;
	logic [LIT_W:0]    tmp_y;
	logic              ge_x;
	logic              ge_y;

	logic [LW_W-1:0]   weight;
	logic [CW_W-1:0]   wcmp;
	logic              found;
	logic              hold;
	logic [SUM_W-1:0]  sum_x;
	logic [SUM_W-1:0]  sum_y;
	logic [CENT_W-1:0] cx;
	logic [CENT_W-1:0] cy;
	logic [WX_W-1:0]   wide_ext;
	logic [RX_W-1:0]   rows_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q       <= RST_THRESHOLD;
			frame_width_q     <= RST_FRAME_SIZE;
			frame_height_q    <= RST_FRAME_SIZE;
			min_weight_q      <= RST_MIN_WEIGHT;
			max_weight_q      <= RST_MAX_WEIGHT;
			weight_check_on_q <= 1'b0;
			offset_x_q        <= '0;
			offset_y_q        <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_THRESHOLD:       threshold_q       <= cfg_data[PIX_W-1:0];
				REG_FRAME_WIDTH:     frame_width_q     <= cfg_data[SIZE_W-1:0];
				REG_FRAME_HEIGHT:    frame_height_q    <= cfg_data[SIZE_W-1:0];
				REG_MIN_WEIGHT:      min_weight_q      <= cfg_data[WGT_W-1:0];
				REG_MAX_WEIGHT:      max_weight_q      <= cfg_data[WGT_W-1:0];
				REG_WEIGHT_CHECK_ON: weight_check_on_q <= cfg_data[0];
				REG_OFFSET_X:        offset_x_q        <= cfg_data[OFS_W-1:0];
				REG_OFFSET_Y:        offset_y_q        <= cfg_data[OFS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = WD_W'(1);
		end else if (CMPW_W'(frame_width_q) > CMPW_W'(MAX_WIDTH)) begin
			w_eff = WD_W'(MAX_WIDTH);
		end else begin
			w_eff = WD_W'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = HT_W'(1);
		end else if (CMPH_W'(frame_height_q) > CMPH_W'(MAX_HEIGHT)) begin
			h_eff = HT_W'(MAX_HEIGHT);
		end else begin
			h_eff = HT_W'(frame_height_q);
		end
		lit       = (pixel_in >= threshold_q);
		row_end   = (CMPW_W'(col_q) + CMPW_W'(1)) >= CMPW_W'(w_eff);
		frame_end = row_end && ((CMPH_W'(row_q) + CMPH_W'(1)) >= CMPH_W'(h_eff));
		lit_nx    = lit_q + LIT_W'(lit);
		cm_nx     = cm_q + (lit ? MOM_W'(col_q) : MOM_W'(0));
		rm_nx     = rm_q + (lit ? MOM_W'(row_q) : MOM_W'(0));
		run_nx    = run_q + RUN_W'(lit);
		wide_nx   = (run_nx > wide_q) ? run_nx : wide_q;
		rows_nx   = rows_q + ROWS_W'(run_nx > RUN_W'(MIN_RUN));
	end

	assign sts.frame_end = frame_end;
	assign sts.div_last  = (cnt_q == CNT_W'(QW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			lit_q  <= '0;
			cm_q   <= '0;
			rm_q   <= '0;
			run_q  <= '0;
			wide_q <= '0;
			rows_q <= '0;
		end else if (cmd.step) begin
			if (frame_end) begin
				col_q  <= '0;
				row_q  <= '0;
				lit_q  <= '0;
				cm_q   <= '0;
				rm_q   <= '0;
				run_q  <= '0;
				wide_q <= '0;
				rows_q <= '0;
			end else begin
				lit_q <= lit_nx;
				cm_q  <= cm_nx;
				rm_q  <= rm_nx;
				if (row_end) begin
					col_q  <= '0;
					row_q  <= row_q + ROW_W'(1);
					run_q  <= '0;
					wide_q <= wide_nx;
					rows_q <= rows_nx;
				end else begin
					col_q <= col_q + COL_W'(1);
					run_q <= run_nx;
				end
			end
		end
	end

	always_comb begin
		tmp_x = {remx_q, dvx_q[QW-1]};
		tmp_y = {remy_q, dvy_q[QW-1]};
		ge_x  = (tmp_x >= {1'b0, dvs_q});
		ge_y  = (tmp_y >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.step && frame_end) begin
			dvx_q    <= QW'(cm_nx) << FRAC_BITS;
			dvy_q    <= QW'(rm_nx) << FRAC_BITS;
			remx_q   <= '0;
			remy_q   <= '0;
			dvs_q    <= lit_nx;
			wide_f_q <= wide_nx;
			rows_f_q <= rows_nx;
			pix_f_q  <= lit;
		end else if (cmd.div_step) begin
			remx_q <= ge_x ? LIT_W'(tmp_x - {1'b0, dvs_q}) : tmp_x[LIT_W-1:0];
			remy_q <= ge_y ? LIT_W'(tmp_y - {1'b0, dvs_q}) : tmp_y[LIT_W-1:0];
			dvx_q  <= {dvx_q[QW-2:0], ge_x};
			dvy_q  <= {dvy_q[QW-2:0], ge_y};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.step && frame_end) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_comb begin
		weight   = (LW_W'(dvs_q) << LIT_SHIFT) - LW_W'(dvs_q);
		wcmp     = CW_W'(weight);
		found    = (dvs_q != '0);
		hold     = !weight_check_on_q
			|| ((wcmp >= CW_W'(min_weight_q)) && (wcmp <= CW_W'(max_weight_q)));
		sum_x    = SUM_W'(dvx_q) + (SUM_W'(offset_x_q) << FRAC_BITS);
		sum_y    = SUM_W'(dvy_q) + (SUM_W'(offset_y_q) << FRAC_BITS);
		cx       = (sum_x > SUM_W'(CENT_MAX)) ? CENT_MAX : sum_x[CENT_W-1:0];
		cy       = (sum_y > SUM_W'(CENT_MAX)) ? CENT_MAX : sum_y[CENT_W-1:0];
		wide_ext = WX_W'(wide_f_q);
		rows_ext = RX_W'(rows_f_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
		end else if (cmd.push_final && found) begin
			last_x_q <= cx;
			last_y_q <= cy;
		end
	end

	always_comb begin
		res = '0;
		if (cmd.push_final) begin
			res.pixel_out    = pix_f_q ? LIT_VALUE : '0;
			res.frame_done   = 1'b1;
			res.object_found = found;
			res.object_hold  = hold;
			res.centroid_x   = found ? cx : last_x_q;
			res.centroid_y   = found ? cy : last_y_q;
			res.widest_row   = wide_ext[CNT_OUT_W-1:0];
			res.rows_lit     = rows_ext[CNT_OUT_W-1:0];
			res.blob_weight  = (wcmp > CW_W'(WEIGHT_MAX)) ? WEIGHT_MAX : wcmp[WGT_W-1:0];
		end else begin
			res.pixel_out = lit ? LIT_VALUE : '0;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tbc_outq.sv =====
// Two-entry result queue between the datapath and the result channel.
`default_nettype none
module tbc_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tbc_pkg::res_t din,
	output logic          full,
	output logic          out_valid,
	input  logic          out_ready,
	output tbc_pkg::res_t dout
);
	import tbc_pkg::*;

	res_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign dout      = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/thresholded_blob_centroid_core.sv =====
// Top level of the thresholded blob centroid core.
//
//   channel   | modport | word                         | handshake
//   pixels    | sink    | pixel_in (8)                 | valid/ready
//   results   | source  | pixel_out .. blob_weight     | valid/ready
//   cfg       | write   | cfg_index (3), cfg_data (28) | cfg_we, no wait
//
// A pixel's word enters a two-entry result queue. After a window's last pixel,
// input is held while the x and y restoring dividers work out QW quotient bits,
// one quotient bit per cycle, QW being the moment width plus FRAC_BITS (34 at
// default parameters). Reset sets control state and configuration to defaults
// at once. Input is taken with queue room and no window result pending.
`default_nettype none
module thresholded_blob_centroid_core #(
	parameter int MAX_WIDTH  = tbc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = tbc_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = tbc_pkg::DEF_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbc_pkg::CFG_DATA_W-1:0] cfg_data,
	tbc_pix_if.sink                        pixels,
	tbc_res_if.source                      results
);
	import tbc_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	res_t    res_word;
	res_t    q_word;
	logic    q_full;
	logic    in_ready;

	tbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixels.valid),
		.in_ready (in_ready),
		.q_full   (q_full),
		.sts      (sts),
		.cmd      (cmd)
	);

	tbc_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel_in  (pixels.pixel_in),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res_word)
	);

	tbc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd.push),
		.din       (res_word),
		.full      (q_full),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.dout      (q_word)
	);

	assign pixels.ready         = in_ready;
	assign results.pixel_out    = q_word.pixel_out;
	assign results.frame_done   = q_word.frame_done;
	assign results.object_found = q_word.object_found;
	assign results.object_hold  = q_word.object_hold;
	assign results.centroid_x   = q_word.centroid_x;
	assign results.centroid_y   = q_word.centroid_y;
	assign results.widest_row   = q_word.widest_row;
	assign results.rows_lit     = q_word.rows_lit;
	assign results.blob_weight  = q_word.blob_weight;

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !q_full)
		else $error("result pushed into a full queue");

	a_stall_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && sts.frame_end) |=> !pixels.ready)
		else $error("input taken while the window result is pending");

	a_final_word_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_final |-> (res_word.frame_done && !cmd.step))
		else $error("window result without frame_done or overlapped with a pixel");

	a_pixel_word_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && !cmd.push_final) |-> !res_word.frame_done)
		else $error("pixel word carries frame_done");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Testbench of the thresholded blob centroid core: directed and random streams checked against a predictor.
module tb;
	import tbc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [SIZE_W-1:0] MAX_W = SIZE_W'(DEF_MAX_WIDTH);
	localparam logic [SIZE_W-1:0] MAX_H = SIZE_W'(DEF_MAX_HEIGHT);
	localparam int FRAC = DEF_FRAC_BITS;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_REPORTS = 100;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tbc_pix_if pix();
	tbc_res_if res();

	thresholded_blob_centroid_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixels   (pix),
		.results  (res)
	);

	// register copies
	logic [PIX_W-1:0]  thr = RST_THRESHOLD;
	logic [SIZE_W-1:0] fw = RST_FRAME_SIZE;
	logic [SIZE_W-1:0] fh = RST_FRAME_SIZE;
	logic [WGT_W-1:0]  wmin = RST_MIN_WEIGHT;
	logic [WGT_W-1:0]  wmax = RST_MAX_WEIGHT;
	logic              wchk = 1'b0;
	logic [OFS_W-1:0]  ofx = '0;
	logic [OFS_W-1:0]  ofy = '0;

	// frame accumulators
	logic [10:0]       col = '0;
	logic [10:0]       row = '0;
	logic [20:0]       lit_cnt = '0;
	logic [30:0]       col_moment = '0;
	logic [30:0]       row_moment = '0;
	logic [10:0]       run_len = '0;
	logic [10:0]       widest = '0;
	logic [10:0]       rows_over = '0;
	logic [CENT_W-1:0] last_cx = '0;
	logic [CENT_W-1:0] last_cy = '0;

	logic [PIX_W-1:0] pixel_queue[$];
	res_t             expected_words[$];
	int               errors = 0;
	int               src_idle_pct = 0;
	int               snk_idle_pct = 0;
	bit               pix_taken = 1'b0;

	function automatic void enqueue_pixel(logic [PIX_W-1:0] p);
		pixel_queue = {pixel_queue, p};
	endfunction

	function automatic logic [CENT_W-1:0] fixed_point_mean(logic [30:0] moment,
			logic [20:0] count, logic [OFS_W-1:0] ofs);
		logic [63:0] v;
		v = ({33'b0, moment} << FRAC) / {43'b0, count} + ({52'b0, ofs} << FRAC);
		return (v > {47'b0, CENT_MAX}) ? CENT_MAX : v[CENT_W-1:0];
	endfunction

	function automatic res_t centroid_step(logic [PIX_W-1:0] p);
		res_t r;
		logic [10:0] w;
		logic [10:0] h;
		logic lit;
		logic row_end;
		logic frame_end;
		logic [63:0] wgt;
		r = '0;
		w = (fw == 0) ? 11'd1 : ((fw > MAX_W) ? MAX_W : fw);
		h = (fh == 0) ? 11'd1 : ((fh > MAX_H) ? MAX_H : fh);
		lit = p >= thr;
		row_end = (col + 11'd1) >= w;
		frame_end = row_end && ((row + 11'd1) >= h);
		r.pixel_out = lit ? LIT_VALUE : '0;
		if (lit) begin
			lit_cnt++;
			col_moment += 31'(col);
			row_moment += 31'(row);
			run_len++;
		end
		if (row_end) begin
			if (run_len > 11'(MIN_RUN)) rows_over++;
			if (run_len > widest) widest = run_len;
			run_len = '0;
			col = '0;
			row++;
		end else begin
			col++;
		end
		if (frame_end) begin
			wgt = {43'b0, lit_cnt} * 64'd255;
			if (lit_cnt != 0) begin
				last_cx = fixed_point_mean(col_moment, lit_cnt, ofx);
				last_cy = fixed_point_mean(row_moment, lit_cnt, ofy);
			end
			r.frame_done = 1'b1;
			r.object_found = lit_cnt != 0;
			r.object_hold = wchk ? (wgt >= {36'b0, wmin} && wgt <= {36'b0, wmax}) : 1'b1;
			r.centroid_x = last_cx;
			r.centroid_y = last_cy;
			r.widest_row = widest;
			r.rows_lit = rows_over;
			r.blob_weight = (wgt > {36'b0, WEIGHT_MAX}) ? WEIGHT_MAX : wgt[WGT_W-1:0];
			col = '0;
			row = '0;
			lit_cnt = '0;
			col_moment = '0;
			row_moment = '0;
			run_len = '0;
			widest = '0;
			rows_over = '0;
		end
		return r;
	endfunction

	task automatic check_field(string name, logic [27:0] want, logic [27:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		if (arst_n && (!pix.valid || pix_taken)) begin
			if (pixel_queue.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
				pix.pixel_in <= pixel_queue.pop_front();
				pix.valid <= 1'b1;
			end else begin
				pix.valid <= 1'b0;
			end
		end
		if (arst_n)
			res.ready <= $urandom_range(99) >= snk_idle_pct;
	end

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n) begin
			pix_taken = pix.valid && pix.ready;
			if (pix_taken)
				expected_words = {expected_words, centroid_step(pix.pixel_in)};
			if (res.valid && res.ready) begin
				got.pixel_out = res.pixel_out;
				got.frame_done = res.frame_done;
				got.object_found = res.object_found;
				got.object_hold = res.object_hold;
				got.centroid_x = res.centroid_x;
				got.centroid_y = res.centroid_y;
				got.widest_row = res.widest_row;
				got.rows_lit = res.rows_lit;
				got.blob_weight = res.blob_weight;
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected word expected none, got %h", $time, got);
				end else begin
					want = expected_words.pop_front();
					check_field("pixel_out", want.pixel_out, got.pixel_out);
					check_field("frame_done", want.frame_done, got.frame_done);
					check_field("object_found", want.object_found, got.object_found);
					check_field("object_hold", want.object_hold, got.object_hold);
					check_field("centroid_x", want.centroid_x, got.centroid_x);
					check_field("centroid_y", want.centroid_y, got.centroid_y);
					check_field("widest_row", want.widest_row, got.widest_row);
					check_field("rows_lit", want.rows_lit, got.rows_lit);
					check_field("blob_weight", want.blob_weight, got.blob_weight);
				end
			end
		end else begin
			pix_taken = 1'b0;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_THRESHOLD:       thr = val[PIX_W-1:0];
			REG_FRAME_WIDTH:     fw = val[SIZE_W-1:0];
			REG_FRAME_HEIGHT:    fh = val[SIZE_W-1:0];
			REG_MIN_WEIGHT:      wmin = val[WGT_W-1:0];
			REG_MAX_WEIGHT:      wmax = val[WGT_W-1:0];
			REG_WEIGHT_CHECK_ON: wchk = val[0];
			REG_OFFSET_X:        ofx = val[OFS_W-1:0];
			REG_OFFSET_Y:        ofy = val[OFS_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pixel_queue.size() != 0 || pix.valid || expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] shaded_pixel(int lit_pct);
		if ($urandom_range(99) < lit_pct || thr == 0)
			return PIX_W'($urandom_range(255, int'(thr)));
		return PIX_W'($urandom_range(int'(thr) - 1, 0));
	endfunction

	task automatic random_phase(ref int items);
		int w;
		int h;
		int n;
		int lit_pct;
		int frame_px;
		logic [27:0] lo;
		w = $urandom_range(12, 1);
		h = $urandom_range(6, 1);
		frame_px = w * h;
		write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
		write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(255)));
		if ($urandom_range(1)) begin
			write_reg(REG_OFFSET_X, CFG_DATA_W'($urandom_range(4095)));
			write_reg(REG_OFFSET_Y, CFG_DATA_W'($urandom_range(4095)));
		end
		if ($urandom_range(1)) begin
			write_reg(REG_WEIGHT_CHECK_ON, CFG_DATA_W'($urandom_range(1)));
			if ($urandom_range(3) == 0) begin
				write_reg(REG_MIN_WEIGHT, CFG_DATA_W'($urandom() & 32'hFFFFFFF));
				write_reg(REG_MAX_WEIGHT, CFG_DATA_W'($urandom() & 32'hFFFFFFF));
			end else begin
				lo = 28'($urandom_range(frame_px * 255));
				write_reg(REG_MIN_WEIGHT, lo);
				write_reg(REG_MAX_WEIGHT, CFG_DATA_W'(lo + 28'($urandom_range(frame_px * 255))));
			end
		end
		n = frame_px * $urandom_range(3, 1);
		// leave a frame open now and then
		if ($urandom_range(5) == 0)
			n += $urandom_range(frame_px, 1);
		lit_pct = $urandom_range(100);
		repeat (n) enqueue_pixel(shaded_pixel(lit_pct));
		items += n;
		wait_idle();
	endtask

	initial begin
		int items;
		logic [PIX_W-1:0] directed[$];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pix.valid = 1'b0;
		pix.pixel_in = '0;
		res.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_THRESHOLD, 128);
		write_reg(REG_FRAME_WIDTH, 4);
		write_reg(REG_FRAME_HEIGHT, 2);
		directed = '{8'd0, 8'd127, 8'd128, 8'd255, 8'd255, 8'd0, 8'd255, 8'd1};
		foreach (directed[i]) enqueue_pixel(directed[i]);
		wait_idle();

		// dark frame: centroid repeats without a second offset
		write_reg(REG_OFFSET_X, 4095);
		write_reg(REG_OFFSET_Y, 4095);
		write_reg(REG_WEIGHT_CHECK_ON, 1);
		write_reg(REG_MIN_WEIGHT, 1);
		write_reg(REG_MAX_WEIGHT, 28'hFFFFFFF);
		directed = '{8'd0, 8'd0, 8'd127, 8'd127, 8'd127, 8'd1, 8'd0, 8'd127};
		foreach (directed[i]) enqueue_pixel(directed[i]);
		wait_idle();

		// zero width acts as one, everything lit
		write_reg(REG_THRESHOLD, 0);
		write_reg(REG_FRAME_WIDTH, 0);
		write_reg(REG_FRAME_HEIGHT, 3);
		write_reg(REG_MIN_WEIGHT, 765);
		write_reg(REG_MAX_WEIGHT, 765);
		repeat (3) enqueue_pixel(8'd0);
		wait_idle();

		write_reg(REG_THRESHOLD, 255);
		write_reg(REG_FRAME_WIDTH, 7);
		write_reg(REG_FRAME_HEIGHT, 1);
		write_reg(REG_WEIGHT_CHECK_ON, 0);
		directed = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254};
		foreach (directed[i]) enqueue_pixel(directed[i]);
		wait_idle();

		// oversized window left open, then shrunk under the running counters
		write_reg(REG_FRAME_WIDTH, 11'h7FF);
		write_reg(REG_FRAME_HEIGHT, 1);
		write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(255)));
		write_reg(REG_OFFSET_X, 4095);
		repeat (20) enqueue_pixel(shaded_pixel(90));
		wait_idle();
		write_reg(REG_FRAME_WIDTH, 0);
		write_reg(REG_FRAME_HEIGHT, 11'h7FF);
		write_reg(REG_OFFSET_Y, 4095);
		repeat (20) enqueue_pixel(shaded_pixel(70));
		wait_idle();

		for (int mode = 0; mode < 3; mode++) begin
			src_idle_pct = (mode == 0) ? 19 : ((mode == 1) ? 75 : 0);
			snk_idle_pct = (mode == 0) ? 75 : ((mode == 1) ? 19 : 0);
			items = 0;
			while (items < 110) random_phase(items);
		end

		if (errors == 0 && expected_words.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#(10_000_000);
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== thresholded_blob_centroid_core.f =====
rtl/tbc_pkg.sv
rtl/tbc_ifs.sv
rtl/tbc_ctrl.sv
rtl/tbc_dp.sv
rtl/tbc_outq.sv
rtl/thresholded_blob_centroid_core.sv
test/tb.sv
